// ----- hw/rtl/icr_pkg.sv -----
// Shared constants, types and the palette table of the iteration count colour ramp.
// Used by the channel interfaces and by the top level; depends on nothing else.
package icr_pkg;

   localparam int unsigned ITER_BITS_DEF = 16;

   localparam int unsigned PERIOD_W   = 16;
   localparam int unsigned SCHEME_W   = 2;
   localparam int unsigned COLOR_W    = 8;
   localparam int unsigned CSR_IDX_W  = 1;
   localparam int unsigned CSR_DATA_W = 16;

   localparam int unsigned NUM_SCHEMES = 3;
   localparam int unsigned NUM_STOPS   = 5;
   localparam int unsigned NUM_SEGS    = NUM_STOPS - 1;
   localparam int unsigned NUM_CH      = 3;
   localparam int unsigned STOP_IDX_W  = 3;
   localparam int unsigned SEG_IDX_W   = 2;

   // Stop positions in ten-thousandths of the period.
   localparam int unsigned POS_ONE = 10000;
   localparam int unsigned STOP_POS [0:NUM_STOPS-1] = '{0, 2600, 5200, 7425, 10000};

   // r * POS_ONE for r below 65535, and one segment width times the period.
   localparam int unsigned RATIO_W = 30;
   localparam int unsigned SEG_W   = 28;
   localparam int unsigned QUO_W   = COLOR_W;
   localparam int unsigned PROD_W  = SEG_W + QUO_W;

   typedef logic [COLOR_W-1:0]   color_type;
   typedef logic [SCHEME_W-1:0]  scheme_type;
   typedef logic [CSR_IDX_W-1:0] csr_idx_type;

   localparam csr_idx_type CSR_COLOR_SCHEME = 1'd0;
   localparam csr_idx_type CSR_PERIOD       = 1'd1;

   localparam scheme_type SCHEME_PASTEL  = 2'd0;
   localparam scheme_type SCHEME_BURNING = 2'd1;
   localparam scheme_type SCHEME_DEFAULT = 2'd2;

   localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd64;

   localparam color_type PALETTE [0:NUM_SCHEMES-1][0:NUM_STOPS-1][0:NUM_CH-1] = '{
      '{ '{8'd62,  8'd0,   8'd12},  '{8'd124, 8'd11,  8'd43},  '{8'd251, 8'd75,  8'd78},
         '{8'd124, 8'd11,  8'd43},  '{8'd62,  8'd12,  8'd17} },
      '{ '{8'd0,   8'd0,   8'd0},   '{8'd127, 8'd0,   8'd21},  '{8'd255, 8'd0,   8'd43},
         '{8'd255, 8'd127, 8'd43},  '{8'd255, 8'd255, 8'd43} },
      '{ '{8'd0,   8'd7,   8'd100}, '{8'd32,  8'd107, 8'd203}, '{8'd237, 8'd255, 8'd255},
         '{8'd255, 8'd170, 8'd0},   '{8'd0,   8'd7,   8'd100} }
   };

endpackage

// ----- hw/rtl/icr_if.sv -----
// Valid/ready channel interfaces of the iteration count colour ramp.
// Depends on icr_pkg for widths.
interface icr_req_if #(
   parameter int unsigned ITER_BITS = icr_pkg::ITER_BITS_DEF
) ();
   logic                        valid;
   logic                        ready;
   logic signed [ITER_BITS:0]   iter_count;

   modport source (output valid, output iter_count, input ready);
   modport sink   (input valid, input iter_count, output ready);
endinterface

interface icr_rsp_if ();
   logic                          valid;
   logic                          ready;
   logic [icr_pkg::COLOR_W-1:0]   red;
   logic [icr_pkg::COLOR_W-1:0]   green;
   logic [icr_pkg::COLOR_W-1:0]   blue;

   modport source (output valid, output red, output green, output blue, input ready);
   modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

// ----- hw/rtl/iteration_count_color_ramp_unit.sv -----
// Top level of the iteration count colour ramp: count in, RGB pixel out.
// Depends on icr_pkg and on the channel interfaces in icr_if.sv.
//
// Each transfer on req_if carries one escape count; each transfer on rsp_if carries
// the pixel for it, in the same order. A negative count gives black. Otherwise the
// count is reduced modulo the period and interpolated along a five-stop gradient of
// the palette picked by color_scheme. Both registers are written through csr_we,
// csr_index and csr_wdata; they should only change while no count is in flight.
//
// Throughput is one count per clock while the receiver does not stall. The modulo
// takes one quotient bit per stage, ITER_BITS stages, then four stages scale, choose
// the segment, fetch the colours and multiply, and eight stages produce the eight
// fraction bits, followed by the output register.
//
// Reset sets color_scheme to the default palette and the period to 64, and empties
// the pipeline. When the receiver stalls, the pixel waits in the output register;
// the pipeline keeps moving while its last stage is empty and otherwise holds,
// dropping req_if.ready, so nothing is lost or repeated.
module iteration_count_color_ramp_unit #(
   parameter int unsigned ITER_BITS = icr_pkg::ITER_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   icr_req_if.sink                             req_if,
   icr_rsp_if.source                           rsp_if,
   input  logic                                csr_we,
   input  logic [icr_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [icr_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int unsigned PW = icr_pkg::PERIOD_W;
   localparam int unsigned RW = icr_pkg::RATIO_W;
   localparam int unsigned SW = icr_pkg::SEG_W;
   localparam int unsigned QW = icr_pkg::QUO_W;
   localparam int unsigned XW = icr_pkg::PROD_W;
   localparam int unsigned CW = icr_pkg::COLOR_W;
   localparam int unsigned NC = icr_pkg::NUM_CH;
   localparam int unsigned NS = icr_pkg::NUM_SEGS;

   // Configuration and values derived from the period.
   icr_pkg::scheme_type   scheme_ff;
   icr_pkg::scheme_type   sel;
   logic [PW-1:0]         period_ff;
   logic [PW-1:0]         per_eff;
   logic [RW-1:0]         thr_in [0:NS-1];
   logic [RW-1:0]         thr_ff [0:NS-1];
   logic [SW-1:0]         seg_in [0:NS-1];
   logic [SW-1:0]         seg_ff [0:NS-1];

   // Pipeline control.
   logic                  adv;
   logic                  out_load;
   logic [ITER_BITS-1:0]  dv_vld_ff;
   logic                  mul_vld_ff;
   logic                  sg_vld_ff;
   logic                  lp_vld_ff;
   logic [QW:0]           e_vld_ff;
   logic                  out_vld_ff;

   // Modulo stages.
   logic [PW-1:0]         dv_rem_ff [0:ITER_BITS-1];
   logic [ITER_BITS-1:0]  dv_raw_ff [0:ITER_BITS-1];
   logic                  dv_blk_ff [0:ITER_BITS-1];

   // Scaling, segment choice and colour fetch.
   logic [RW-1:0]                 mul_r10k_in;
   logic [RW-1:0]                 mul_r10k_ff;
   logic                          mul_blk_ff;
   logic [icr_pkg::SEG_IDX_W-1:0] sg_k_in;
   logic [icr_pkg::SEG_IDX_W-1:0] sg_k_ff;
   logic [RW-1:0]                 sg_r10k_ff;
   logic                          sg_blk_ff;
   logic [icr_pkg::STOP_IDX_W-1:0] lo_stop;
   logic [icr_pkg::STOP_IDX_W-1:0] hi_stop;
   logic [SW-1:0]                 lp_num_in;
   logic [SW-1:0]                 lp_num_ff;
   logic [SW-1:0]                 lp_den_ff;
   icr_pkg::color_type            lp_c1 [0:NC-1];
   icr_pkg::color_type            lp_c0_in [0:NC-1];
   icr_pkg::color_type            lp_c0_ff [0:NC-1];
   icr_pkg::color_type            lp_dabs_in [0:NC-1];
   icr_pkg::color_type            lp_dabs_ff [0:NC-1];
   logic                          lp_dneg_in [0:NC-1];
   logic                          lp_dneg_ff [0:NC-1];
   logic                          lp_blk_ff;

   // Product and fraction stages; index 0 holds the product.
   logic [XW-1:0]         e_p_ff    [0:QW][0:NC-1];
   logic [QW-1:0]         e_q_ff    [0:QW][0:NC-1];
   icr_pkg::color_type    e_c0_ff   [0:QW][0:NC-1];
   logic                  e_dneg_ff [0:QW][0:NC-1];
   logic [SW-1:0]         e_den_ff  [0:QW];
   logic                  e_blk_ff  [0:QW];

   icr_pkg::color_type    out_color_in [0:NC-1];
   icr_pkg::color_type    out_color_ff [0:NC-1];

   // ---------------------------------------------------------------- configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         scheme_ff <= icr_pkg::SCHEME_DEFAULT;
         period_ff <= icr_pkg::PERIOD_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            icr_pkg::CSR_COLOR_SCHEME: scheme_ff <= csr_wdata[icr_pkg::SCHEME_W-1:0];
            icr_pkg::CSR_PERIOD:       period_ff <= csr_wdata[PW-1:0];
            default:                   scheme_ff <= scheme_ff;
         endcase
      end
   end

   // A period of zero behaves as one; the unused palette code picks the default.
   assign per_eff = (period_ff == '0) ? PW'(1) : period_ff;
   assign sel     = (scheme_ff > icr_pkg::SCHEME_DEFAULT) ? icr_pkg::SCHEME_DEFAULT : scheme_ff;

   always_comb begin
      for (int k = 0; k < NS; k++) begin
         thr_in[k] = RW'(per_eff) * RW'(icr_pkg::STOP_POS[k]);
         seg_in[k] = SW'(per_eff) * SW'(icr_pkg::STOP_POS[k+1] - icr_pkg::STOP_POS[k]);
      end
   end

   always_ff @(posedge clock) begin
      thr_ff <= thr_in;
      seg_ff <= seg_in;
   end

   // ---------------------------------------------------------------- flow control
   // The output register takes a new pixel when empty or when its transfer happens.
   // The rest of the pipeline may also move while its last stage holds nothing.
   assign out_load     = !out_vld_ff || rsp_if.ready;
   assign adv          = out_load || !e_vld_ff[QW];
   assign req_if.ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_vld_ff  <= '0;
         mul_vld_ff <= 1'b0;
         sg_vld_ff  <= 1'b0;
         lp_vld_ff  <= 1'b0;
         e_vld_ff   <= '0;
      end else if (adv) begin
         dv_vld_ff  <= {dv_vld_ff[ITER_BITS-2:0], req_if.valid};
         mul_vld_ff <= dv_vld_ff[ITER_BITS-1];
         sg_vld_ff  <= mul_vld_ff;
         lp_vld_ff  <= sg_vld_ff;
         e_vld_ff   <= {e_vld_ff[QW-1:0], lp_vld_ff};
      end
   end

   // ---------------------------------------------------------------- modulo by period
   // Restoring division, one dividend bit per stage; only the remainder is kept.
   for (genvar gj = 0; gj < ITER_BITS; gj++) begin : g_mod
      logic [PW-1:0]        rem_prev;
      logic [ITER_BITS-1:0] raw_prev;
      logic                 blk_prev;
      logic [PW:0]          trial;
      logic [PW-1:0]        rem_in;

      if (gj == 0) begin : g_first
         assign rem_prev = '0;
         assign raw_prev = req_if.iter_count[ITER_BITS-1:0];
         assign blk_prev = req_if.iter_count[ITER_BITS];
      end else begin : g_next
         assign rem_prev = dv_rem_ff[gj-1];
         assign raw_prev = dv_raw_ff[gj-1];
         assign blk_prev = dv_blk_ff[gj-1];
      end

      assign trial  = {rem_prev, raw_prev[ITER_BITS-1-gj]};
      assign rem_in = (trial >= {1'b0, per_eff}) ? PW'(trial - {1'b0, per_eff})
                                                 : trial[PW-1:0];

      always_ff @(posedge clock) begin
         if (adv) begin
            dv_rem_ff[gj] <= rem_in;
            dv_raw_ff[gj] <= raw_prev;
            dv_blk_ff[gj] <= blk_prev;
         end
      end
   end

   // ---------------------------------------------------------------- scale and segment
   assign mul_r10k_in = RW'(dv_rem_ff[ITER_BITS-1]) * RW'(icr_pkg::POS_ONE);

   always_ff @(posedge clock) begin
      if (adv) begin
         mul_r10k_ff <= mul_r10k_in;
         mul_blk_ff  <= dv_blk_ff[ITER_BITS-1];
      end
   end

   // The first segment whose upper stop is not below the scaled remainder.
   always_comb begin
      priority if (mul_r10k_ff <= thr_ff[1]) begin
         sg_k_in = 2'd0;
      end else if (mul_r10k_ff <= thr_ff[2]) begin
         sg_k_in = 2'd1;
      end else if (mul_r10k_ff <= thr_ff[3]) begin
         sg_k_in = 2'd2;
      end else begin
         sg_k_in = 2'd3;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sg_k_ff    <= sg_k_in;
         sg_r10k_ff <= mul_r10k_ff;
         sg_blk_ff  <= mul_blk_ff;
      end
   end

   // ---------------------------------------------------------------- colour fetch
   assign lo_stop   = {1'b0, sg_k_ff};
   assign hi_stop   = lo_stop + icr_pkg::STOP_IDX_W'(1);
   assign lp_num_in = SW'(sg_r10k_ff - thr_ff[sg_k_ff]);

   always_comb begin
      for (int ch = 0; ch < NC; ch++) begin
         lp_c0_in[ch]   = icr_pkg::PALETTE[sel][lo_stop][ch];
         lp_c1[ch]      = icr_pkg::PALETTE[sel][hi_stop][ch];
         lp_dneg_in[ch] = lp_c1[ch] < lp_c0_in[ch];
         lp_dabs_in[ch] = lp_dneg_in[ch] ? lp_c0_in[ch] - lp_c1[ch]
                                         : lp_c1[ch] - lp_c0_in[ch];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         lp_num_ff  <= lp_num_in;
         lp_den_ff  <= seg_ff[sg_k_ff];
         lp_c0_ff   <= lp_c0_in;
         lp_dabs_ff <= lp_dabs_in;
         lp_dneg_ff <= lp_dneg_in;
         lp_blk_ff  <= sg_blk_ff;
      end
   end

   // ---------------------------------------------------------------- product
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int ch = 0; ch < NC; ch++) begin
            e_p_ff[0][ch]    <= XW'(lp_num_ff) * XW'(lp_dabs_ff[ch]);
            e_q_ff[0][ch]    <= '0;
            e_c0_ff[0][ch]   <= lp_c0_ff[ch];
            e_dneg_ff[0][ch] <= lp_dneg_ff[ch];
         end
         e_den_ff[0] <= lp_den_ff;
         e_blk_ff[0] <= lp_blk_ff;
      end
   end

   // ---------------------------------------------------------------- fraction bits
   // The product is below the denominator times 256, so eight quotient bits suffice.
   for (genvar gs = 0; gs < QW; gs++) begin : g_frac
      logic [XW-1:0] shifted;
      logic [XW-1:0] p_in [0:NC-1];
      logic [QW-1:0] q_in [0:NC-1];

      assign shifted = XW'(e_den_ff[gs]) << (QW - 1 - gs);

      always_comb begin
         for (int ch = 0; ch < NC; ch++) begin
            if (e_p_ff[gs][ch] >= shifted) begin
               p_in[ch] = e_p_ff[gs][ch] - shifted;
               q_in[ch] = {e_q_ff[gs][ch][QW-2:0], 1'b1};
            end else begin
               p_in[ch] = e_p_ff[gs][ch];
               q_in[ch] = {e_q_ff[gs][ch][QW-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            e_p_ff[gs+1]    <= p_in;
            e_q_ff[gs+1]    <= q_in;
            e_c0_ff[gs+1]   <= e_c0_ff[gs];
            e_dneg_ff[gs+1] <= e_dneg_ff[gs];
            e_den_ff[gs+1]  <= e_den_ff[gs];
            e_blk_ff[gs+1]  <= e_blk_ff[gs];
         end
      end
   end

   // ---------------------------------------------------------------- output register
   // A falling ramp rounds towards minus infinity, so a non-zero remainder takes one more.
   always_comb begin
      for (int ch = 0; ch < NC; ch++) begin
         if (e_blk_ff[QW]) begin
            out_color_in[ch] = '0;
         end else if (e_dneg_ff[QW][ch]) begin
            out_color_in[ch] = e_c0_ff[QW][ch] - e_q_ff[QW][ch]
                             - CW'(e_p_ff[QW][ch] != '0);
         end else begin
            out_color_in[ch] = e_c0_ff[QW][ch] + e_q_ff[QW][ch];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (out_load) begin
         out_vld_ff <= e_vld_ff[QW];
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_color_ff <= out_color_in;
      end
   end

   assign rsp_if.valid = out_vld_ff;
   assign rsp_if.red   = out_color_ff[0];
   assign rsp_if.green = out_color_ff[1];
   assign rsp_if.blue  = out_color_ff[2];

`ifndef SYNTH
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (out_vld_ff && !rsp_if.ready && e_vld_ff[QW]) |-> !req_if.ready)
      else $error("Input taken while the full pipeline is blocked.");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !adv |=> ($stable(dv_vld_ff) && $stable(e_vld_ff) && $stable(lp_vld_ff)))
      else $error("Pipeline valid bits moved during a stall.");

   a_drain: assert property (@(posedge clock) disable iff (reset)
      (out_vld_ff && rsp_if.ready && !e_vld_ff[QW]) |=> !out_vld_ff)
      else $error("Pixel repeated after its transfer.");

   a_black: assert property (@(posedge clock) disable iff (reset)
      (adv && e_vld_ff[QW] && e_blk_ff[QW]) |=>
      (rsp_if.valid && rsp_if.red == '0 && rsp_if.green == '0 && rsp_if.blue == '0))
      else $error("Negative count did not give a black pixel.");
`endif

endmodule

// ----- verif/tb_iteration_count_color_ramp_unit.sv -----
// Self-checking testbench of iteration_count_color_ramp_unit: directed and random counts.
// Uses icr_pkg for types and register indexes, and icr_if.sv for the two channels.
// Every pixel is compared with the directed table or with an own exact integer model of the colour ramp.
module tb_iteration_count_color_ramp_unit;

   localparam int unsigned ITER_BITS = icr_pkg::ITER_BITS_DEF;
   localparam int unsigned CNT_W     = ITER_BITS + 1;
   localparam longint      MAX_COUNT = (longint'(1) << ITER_BITS) - 1;
   localparam longint      RAMP_ONE  = 10000;
   localparam int          RX_PHASES = 10;
   localparam int          PHASE_LEN = 128;
   localparam int unsigned DATA_W    = icr_pkg::CSR_DATA_W;
   localparam int unsigned SPARE_W   = icr_pkg::CSR_DATA_W - icr_pkg::SCHEME_W;

   // Code 3 is not a palette of its own; the block falls back to the default one.
   localparam icr_pkg::scheme_type SCHEME_SPARE = 2'd3;

   typedef logic signed [CNT_W-1:0]      count_type;
   typedef logic [icr_pkg::PERIOD_W-1:0] period_type;

   typedef struct packed {
      icr_pkg::color_type red;
      icr_pkg::color_type green;
      icr_pkg::color_type blue;
   } pixel_type;

   typedef struct packed {
      bit                  load_cfg;
      icr_pkg::scheme_type scheme;
      period_type          period;
      int                  count;
      bit                  known;
      pixel_type           pixel;
   } ramp_case_type;

   localparam longint STOP_AT [5] = '{0, 2600, 5200, 7425, 10000};

   localparam int RAMP_RGB [3][5][3] = '{
      '{'{62, 0, 12}, '{124, 11, 43}, '{251, 75, 78}, '{124, 11, 43}, '{62, 12, 17}},
      '{'{0, 0, 0}, '{127, 0, 21}, '{255, 0, 43}, '{255, 127, 43}, '{255, 255, 43}},
      '{'{0, 7, 100}, '{32, 107, 203}, '{237, 255, 255}, '{255, 170, 0}, '{0, 7, 100}}
   };

   // The first rows run with the register values left by reset.
   localparam ramp_case_type DIR_CASES [23] = '{
      '{1'b0, icr_pkg::SCHEME_DEFAULT, 16'd64, -1, 1'b1, '{8'd0, 8'd0, 8'd0}},
      '{1'b0, icr_pkg::SCHEME_DEFAULT, 16'd64, 0, 1'b1, '{8'd0, 8'd7, 8'd100}},
      '{1'b0, icr_pkg::SCHEME_DEFAULT, 16'd64, 64, 1'b1, '{8'd0, 8'd7, 8'd100}},
      '{1'b0, icr_pkg::SCHEME_DEFAULT, 16'd64, 63, 1'b0, '{8'd0, 8'd0, 8'd0}},
      '{1'b0, icr_pkg::SCHEME_DEFAULT, 16'd64, 65535, 1'b0, '{8'd0, 8'd0, 8'd0}},
      '{1'b0, icr_pkg::SCHEME_DEFAULT, 16'd64, -65536, 1'b1, '{8'd0, 8'd0, 8'd0}},
      '{1'b1, icr_pkg::SCHEME_PASTEL, 16'd10000, 0, 1'b1, '{8'd62, 8'd0, 8'd12}},
      '{1'b0, icr_pkg::SCHEME_PASTEL, 16'd10000, 2600, 1'b1, '{8'd124, 8'd11, 8'd43}},
      '{1'b0, icr_pkg::SCHEME_PASTEL, 16'd10000, 5200, 1'b1, '{8'd251, 8'd75, 8'd78}},
      '{1'b0, icr_pkg::SCHEME_PASTEL, 16'd10000, 7425, 1'b1, '{8'd124, 8'd11, 8'd43}},
      '{1'b0, icr_pkg::SCHEME_PASTEL, 16'd10000, 9999, 1'b0, '{8'd0, 8'd0, 8'd0}},
      '{1'b0, icr_pkg::SCHEME_PASTEL, 16'd10000, 2601, 1'b0, '{8'd0, 8'd0, 8'd0}},
      '{1'b1, icr_pkg::SCHEME_BURNING, 16'd10000, 5200, 1'b1, '{8'd255, 8'd0, 8'd43}},
      '{1'b0, icr_pkg::SCHEME_BURNING, 16'd10000, 7425, 1'b1, '{8'd255, 8'd127, 8'd43}},
      '{1'b0, icr_pkg::SCHEME_BURNING, 16'd10000, 10000, 1'b1, '{8'd0, 8'd0, 8'd0}},
      '{1'b1, SCHEME_SPARE, 16'd10000, 2600, 1'b1, '{8'd32, 8'd107, 8'd203}},
      '{1'b1, SCHEME_SPARE, 16'd0, 12345, 1'b1, '{8'd0, 8'd7, 8'd100}},
      '{1'b0, SCHEME_SPARE, 16'd0, 65535, 1'b1, '{8'd0, 8'd7, 8'd100}},
      '{1'b1, icr_pkg::SCHEME_DEFAULT, 16'd65535, 65535, 1'b1, '{8'd0, 8'd7, 8'd100}},
      '{1'b0, icr_pkg::SCHEME_DEFAULT, 16'd65535, 65534, 1'b0, '{8'd0, 8'd0, 8'd0}},
      '{1'b0, icr_pkg::SCHEME_DEFAULT, 16'd65535, -1, 1'b1, '{8'd0, 8'd0, 8'd0}},
      '{1'b1, icr_pkg::SCHEME_PASTEL, 16'd1, 5, 1'b1, '{8'd62, 8'd0, 8'd12}},
      '{1'b0, icr_pkg::SCHEME_PASTEL, 16'd1, -2, 1'b1, '{8'd0, 8'd0, 8'd0}}
   };

   logic                         clock = 1'b0;
   logic                         reset;
   logic                         csr_we;
   icr_pkg::csr_idx_type         csr_index;
   logic [DATA_W-1:0]            csr_wdata;

   icr_pkg::scheme_type cur_scheme = icr_pkg::SCHEME_DEFAULT;
   period_type          cur_period = icr_pkg::PERIOD_RESET;
   pixel_type           pending_pixels [$];
   int                  error_count = 0;
   bit                  tx_idle_on = 1'b1;
   bit                  rx_idle_on = 1'b1;

   icr_req_if #(.ITER_BITS(ITER_BITS)) req_if ();
   icr_rsp_if                          rsp_if ();

   iteration_count_color_ramp_unit #(.ITER_BITS(ITER_BITS)) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .rsp_if    (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic pixel_type ramp_pixel(input count_type cnt,
                                            input icr_pkg::scheme_type sch,
                                            input period_type per_reg);
      pixel_type          px;
      longint             span, rem, num, den, prod, quot, lo, hi;
      int                 pal, seg;
      icr_pkg::color_type chan [3];
      px = '0;
      if (cnt[CNT_W-1]) return px;
      span = per_reg;
      if (span == 0) span = 1;
      rem  = longint'(cnt) % span;
      pal  = (sch == SCHEME_SPARE) ? int'(icr_pkg::SCHEME_DEFAULT) : int'(sch);
      seg  = 0;
      while (seg < 3 && rem * RAMP_ONE > span * STOP_AT[seg+1]) seg++;
      num = rem * RAMP_ONE - span * STOP_AT[seg];
      den = span * (STOP_AT[seg+1] - STOP_AT[seg]);
      for (int ch = 0; ch < 3; ch++) begin
         lo   = RAMP_RGB[pal][seg][ch];
         hi   = RAMP_RGB[pal][seg+1][ch];
         prod = num * (hi - lo);
         // Division truncates towards zero, so a falling channel with a remainder needs one step down.
         quot = prod / den;
         if (prod % den != 0 && prod < 0) quot--;
         chan[ch] = icr_pkg::color_type'(lo + quot);
      end
      px.red   = chan[0];
      px.green = chan[1];
      px.blue  = chan[2];
      return px;
   endfunction

   task automatic send_count(input count_type cnt, input bit known, input pixel_type given);
      req_if.valid      <= 1'b1;
      req_if.iter_count <= cnt;
      do @(posedge clock); while (!req_if.ready);
      pending_pixels.push_back(known ? given : ramp_pixel(cnt, cur_scheme, cur_period));
   endtask

   task automatic idle_sender();
      if (tx_idle_on && $urandom_range(0, 4) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
   endtask

   // The caller has lowered valid; every pixel in flight must be out before a write.
   task automatic wait_for_pixels();
      while (pending_pixels.size() != 0) @(posedge clock);
   endtask

   task automatic load_ramp_config(input icr_pkg::scheme_type sch, input period_type per,
                                   input logic [SPARE_W-1:0] spare_bits);
      csr_we    <= 1'b1;
      csr_index <= icr_pkg::CSR_COLOR_SCHEME;
      csr_wdata <= {spare_bits, sch};
      @(posedge clock);
      csr_index <= icr_pkg::CSR_PERIOD;
      csr_wdata <= per;
      @(posedge clock);
      csr_we     <= 1'b0;
      cur_scheme  = sch;
      cur_period  = per;
   endtask

   initial begin : receiver
      rsp_if.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (rx_idle_on && $urandom_range(0, 4) == 0) begin
            rsp_if.ready <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         @(posedge clock);
      end
   end

   always @(posedge clock) begin
      pixel_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_pixels.size() == 0) begin
            $error("pixel transfer with no count outstanding: %0d %0d %0d",
                   rsp_if.red, rsp_if.green, rsp_if.blue);
            error_count++;
         end else begin
            want = pending_pixels.pop_front();
            if (rsp_if.red !== want.red) begin
               $error("red: expected %0d, got %0d", want.red, rsp_if.red);
               error_count++;
            end
            if (rsp_if.green !== want.green) begin
               $error("green: expected %0d, got %0d", want.green, rsp_if.green);
               error_count++;
            end
            if (rsp_if.blue !== want.blue) begin
               $error("blue: expected %0d, got %0d", want.blue, rsp_if.blue);
               error_count++;
            end
         end
      end
   end

   initial begin : stimulus
      count_type  cnt;
      period_type per;
      longint     span, v;
      int         sel;
      reset             <= 1'b1;
      req_if.valid      <= 1'b0;
      req_if.iter_count <= '0;
      csr_we            <= 1'b0;
      csr_index         <= icr_pkg::CSR_COLOR_SCHEME;
      csr_wdata         <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (DIR_CASES[i]) begin
         if (DIR_CASES[i].load_cfg) begin
            req_if.valid <= 1'b0;
            wait_for_pixels();
            load_ramp_config(DIR_CASES[i].scheme, DIR_CASES[i].period, '0);
         end
         send_count(count_type'(DIR_CASES[i].count), DIR_CASES[i].known,
                    DIR_CASES[i].pixel);
         idle_sender();
      end

      for (int p = 0; p < RX_PHASES; p++) begin
         case (p)
            0: per = 16'd1;
            1: per = 16'd65535;
            2: per = 16'd0;
            3: per = 16'd10000;
            default: per = $urandom_range(0, 1) ? period_type'($urandom_range(1, 200))
                                               : period_type'($urandom_range(1, 65535));
         endcase
         req_if.valid <= 1'b0;
         wait_for_pixels();
         load_ramp_config(icr_pkg::scheme_type'(p % 4), per, SPARE_W'($urandom));
         // The last phase runs without any idling on either side.
         tx_idle_on = (p != RX_PHASES - 1) && (p % 3 != 2);
         rx_idle_on = (p != RX_PHASES - 1) && (p % 3 != 1);
         span = per;
         if (span == 0) span = 1;
         repeat (PHASE_LEN) begin
            sel = $urandom_range(0, 99);
            if (sel < 8) begin
               cnt = '1;
            end else if (sel < 12) begin
               cnt = {1'b1, ITER_BITS'($urandom)};
            end else if (sel < 47) begin
               // Land on or next to a period wrap, or on or next to a stop boundary.
               v = longint'($urandom_range(0, 32'(MAX_COUNT / span))) * span
                   + longint'($urandom_range(0, 2)) - 1;
               if (sel >= 32) v += (span * STOP_AT[$urandom_range(1, 3)]) / RAMP_ONE;
               if (v < 0) v = 0;
               if (v > MAX_COUNT) v = MAX_COUNT;
               cnt = count_type'(v);
            end else begin
               cnt = {1'b0, ITER_BITS'($urandom)};
            end
            send_count(cnt, 1'b0, '0);
            idle_sender();
         end
      end

      req_if.valid <= 1'b0;
      wait_for_pixels();
      repeat (40) @(posedge clock);
      if (error_count == 0)
         $display("** iteration_count_color_ramp_unit: PASSED **");
      else
         $display("** iteration_count_color_ramp_unit: FAILED **");
      $finish;
   end

   initial begin : watchdog
      #2000000;
      $display("** iteration_count_color_ramp_unit: FAILED **");
      $finish;
   end

endmodule

// ----- iteration_count_color_ramp_unit.f -----
hw/rtl/icr_pkg.sv
hw/rtl/icr_if.sv
hw/rtl/iteration_count_color_ramp_unit.sv
verif/tb_iteration_count_color_ramp_unit.sv
